/* rtl/scl_pkg.sv */
// Shared types and constants for the shell command lexer.
package scl_pkg;

  localparam int unsigned PosBitsDef = 16;
  localparam int unsigned OutPosBits = 16;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOL  = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    TOK_WORD = 2'd0,
    TOK_OP   = 2'd1,
    TOK_END  = 2'd2,
    TOK_ERR  = 2'd3
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DQ   = 2'd1,
    ERR_SQ   = 2'd2,
    ERR_LONG = 2'd3
  } err_code_e;

  typedef enum logic [3:0] {
    MODE_WS      = 4'd0,
    MODE_NUM     = 4'd1,
    MODE_WORD    = 4'd2,
    MODE_COMMENT = 4'd3,
    MODE_DQ      = 4'd4,
    MODE_SQ      = 4'd5,
    MODE_ESC     = 4'd6,
    MODE_ESC_DQ  = 4'd7,
    MODE_ESC_SQ  = 4'd8,
    MODE_GT      = 4'd9,
    MODE_OVER    = 4'd10
  } scan_mode_e;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    tok_kind_e                 token_kind;
    logic [OutPosBits-1:0]     token_start;
    logic [OutPosBits-1:0]     token_length;
    err_code_e                 error_code;
    logic                      last_result;
  } out_item_t;

endpackage

/* rtl/scl_core.sv */
// Next-state and token logic of the lexer for one word.
module scl_core #(
  parameter int unsigned POS_BITS = scl_pkg::PosBitsDef
) (
  input  scl_pkg::scan_mode_e  mode_q_i,
  input  logic [POS_BITS-1:0]  pos_q_i,
  input  logic [POS_BITS-1:0]  start_q_i,
  input  scl_pkg::in_item_t    item_i,
  output scl_pkg::scan_mode_e  mode_d_o,
  output logic [POS_BITS-1:0]  pos_d_o,
  output logic [POS_BITS-1:0]  start_d_o,
  output scl_pkg::out_item_t   res0_o,
  output scl_pkg::out_item_t   res1_o,
  output logic [1:0]           num_o
);
  import scl_pkg::*;

  function automatic logic [OutPosBits-1:0] to_out(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+OutPosBits-1:0] ext;
    ext = {{OutPosBits{1'b0}}, v};
    return ext[OutPosBits-1:0];
  endfunction

  function automatic out_item_t mk(input tok_kind_e k, input logic [POS_BITS-1:0] s,
                                   input logic [POS_BITS-1:0] l, input err_code_e e);
    out_item_t r;
    r.token_kind   = k;
    r.token_start  = to_out(s);
    r.token_length = to_out(l);
    r.error_code   = e;
    r.last_result  = 1'b0;
    return r;
  endfunction

  logic [7:0]          c;
  logic [POS_BITS-1:0] p;
  logic [POS_BITS-1:0] p_inc;
  logic [POS_BITS-1:0] zero;
  logic                blank;
  logic                digit;
  scan_mode_e          ws_mode;
  logic                ws_emit_op;
  scan_mode_e          word_mode;
  scan_mode_e          mode_d;
  logic [POS_BITS-1:0] start_d;
  out_item_t           r0;
  out_item_t           r1;
  logic [1:0]          n;

  assign c     = item_i.char_byte;
  assign p     = pos_q_i;
  assign p_inc = pos_q_i + 1'b1;
  assign zero  = '0;
  assign blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // Mode after a character seen at a token boundary (through the digit and word steps)
  always_comb begin
    ws_emit_op = 1'b0;
    if (c == CH_HASH) begin
      ws_mode = MODE_COMMENT;
    end else if (c == CH_PIPE || c == CH_LT) begin
      ws_mode    = MODE_WS;
      ws_emit_op = 1'b1;
    end else if (blank) begin
      ws_mode = MODE_WS;
    end else if (c == CH_GT) begin
      ws_mode = MODE_GT;
    end else if (digit) begin
      ws_mode = MODE_NUM;
    end else if (c == CH_SQ) begin
      ws_mode = MODE_SQ;
    end else if (c == CH_DQ) begin
      ws_mode = MODE_DQ;
    end else if (c == CH_BSL) begin
      ws_mode = MODE_ESC;
    end else begin
      ws_mode = MODE_WORD;
    end
  end

  // Word-step mode for characters other than '<' and '>'
  always_comb begin
    if (c == CH_SQ) begin
      word_mode = MODE_SQ;
    end else if (c == CH_DQ) begin
      word_mode = MODE_DQ;
    end else if (c == CH_BSL) begin
      word_mode = MODE_ESC;
    end else if (blank) begin
      word_mode = MODE_WS;
    end else begin
      word_mode = MODE_WORD;
    end
  end

  always_comb begin
    mode_d   = mode_q_i;
    pos_d_o  = pos_q_i;
    start_d  = start_q_i;
    r0       = mk(TOK_WORD, zero, zero, ERR_NONE);
    r1       = mk(TOK_WORD, zero, zero, ERR_NONE);
    n        = 2'd0;
    if (item_i.kind == KIND_EOL) begin
      case (mode_q_i)
        MODE_NUM, MODE_WORD, MODE_ESC: begin
          r0 = mk(TOK_WORD, start_q_i, p - start_q_i, ERR_NONE);
          r1 = mk(TOK_END, p, zero, ERR_NONE);
          n  = 2'd2;
        end
        MODE_GT: begin
          r0 = mk(TOK_OP, start_q_i, p - start_q_i, ERR_NONE);
          r1 = mk(TOK_END, p, zero, ERR_NONE);
          n  = 2'd2;
        end
        MODE_DQ, MODE_ESC_DQ: begin
          r0 = mk(TOK_ERR, p, zero, ERR_DQ);
          n  = 2'd1;
        end
        MODE_SQ, MODE_ESC_SQ: begin
          r0 = mk(TOK_ERR, p, zero, ERR_SQ);
          n  = 2'd1;
        end
        MODE_OVER: begin
          r0 = mk(TOK_ERR, p, zero, ERR_LONG);
          n  = 2'd1;
        end
        default: begin
          r0 = mk(TOK_END, p, zero, ERR_NONE);
          n  = 2'd1;
        end
      endcase
      mode_d  = MODE_WS;
      pos_d_o = '0;
      start_d = '0;
    end else if (mode_q_i == MODE_OVER) begin
      mode_d = MODE_OVER;
    end else if (pos_q_i == '1) begin
      // line too long: swallow the rest until end of line
      mode_d = MODE_OVER;
    end else begin
      pos_d_o = p_inc;
      case (mode_q_i)
        MODE_NUM: begin
          if (c == CH_LT) begin
            r0     = mk(TOK_OP, start_q_i, p_inc - start_q_i, ERR_NONE);
            n      = 2'd1;
            mode_d = MODE_WS;
          end else if (c == CH_GT) begin
            mode_d = MODE_GT;
          end else if (!digit) begin
            mode_d = word_mode;
            if (blank) begin
              r0 = mk(TOK_WORD, start_q_i, p - start_q_i, ERR_NONE);
              n  = 2'd1;
            end
          end
        end
        MODE_WORD: begin
          if (c == CH_LT) begin
            r0      = mk(TOK_WORD, start_q_i, p - start_q_i, ERR_NONE);
            r1      = mk(TOK_OP, p, p_inc - p, ERR_NONE);
            n       = 2'd2;
            start_d = p;
            mode_d  = MODE_WS;
          end else if (c == CH_GT) begin
            r0      = mk(TOK_WORD, start_q_i, p - start_q_i, ERR_NONE);
            n       = 2'd1;
            start_d = p;
            mode_d  = MODE_GT;
          end else begin
            mode_d = word_mode;
            if (blank) begin
              r0 = mk(TOK_WORD, start_q_i, p - start_q_i, ERR_NONE);
              n  = 2'd1;
            end
          end
        end
        MODE_COMMENT: begin
          mode_d = MODE_COMMENT;
        end
        MODE_ESC: begin
          mode_d = MODE_WORD;
        end
        MODE_SQ: begin
          if (c == CH_SQ) begin
            mode_d = MODE_WORD;
          end else if (c == CH_BSL) begin
            mode_d = MODE_ESC_SQ;
          end
        end
        MODE_DQ: begin
          if (c == CH_DQ) begin
            mode_d = MODE_WORD;
          end else if (c == CH_BSL) begin
            mode_d = MODE_ESC_DQ;
          end
        end
        MODE_ESC_DQ: begin
          mode_d = MODE_DQ;
        end
        MODE_ESC_SQ: begin
          mode_d = MODE_SQ;
        end
        MODE_GT: begin
          if (c == CH_GT) begin
            r0     = mk(TOK_OP, start_q_i, p_inc - start_q_i, ERR_NONE);
            n      = 2'd1;
            mode_d = MODE_WS;
          end else begin
            // close the '>' here, then rescan c at a token boundary
            r0     = mk(TOK_OP, start_q_i, p - start_q_i, ERR_NONE);
            mode_d = ws_mode;
            if (!blank) begin
              start_d = p;
            end
            if (ws_emit_op) begin
              r1 = mk(TOK_OP, p, p_inc - p, ERR_NONE);
              n  = 2'd2;
            end else begin
              n  = 2'd1;
            end
          end
        end
        default: begin
          mode_d = ws_mode;
          if (!blank) begin
            start_d = p;
          end
          if (ws_emit_op) begin
            r0 = mk(TOK_OP, p, p_inc - p, ERR_NONE);
            n  = 2'd1;
          end
        end
      endcase
    end
    if (n == 2'd2) begin
      r1.last_result = 1'b1;
    end else begin
      r0.last_result = 1'b1;
    end
  end

  assign mode_d_o  = mode_d;
  assign start_d_o = start_d;
  assign res0_o    = r0;
  assign res1_o    = r1;
  assign num_o     = n;

endmodule

/* rtl/scl_resq.sv */
// Two-entry result queue: takes up to two words at once, hands out one per cycle while pop_i is high.
module scl_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_num_i,
  input  scl_pkg::out_item_t push0_i,
  input  scl_pkg::out_item_t push1_i,
  input  logic               pop_i,
  output logic [1:0]         free_o,
  output logic [1:0]         count_o,
  output logic               valid_o,
  output scl_pkg::out_item_t head_o
);
  import scl_pkg::*;

  out_item_t  slot_q [2];
  out_item_t  slot_d [2];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic [1:0] cnt_left;

  assign cnt_left = cnt_q - {1'b0, pop_i};
  assign free_o   = 2'd2 - cnt_left;

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (pop_i) begin
      slot_d[0] = slot_q[1];
    end
    case (push_num_i)
      2'd1: begin
        slot_d[cnt_left[0]] = push0_i;
      end
      2'd2: begin
        slot_d[0] = push0_i;
        slot_d[1] = push1_i;
      end
      default: begin
      end
    endcase
    cnt_d = cnt_left + push_num_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign count_o = cnt_q;
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[0];

endmodule

/* rtl/shell_command_lexer.sv */
// Shell command lexer: input word register, lexer logic, result queue.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one character word
// per cycle while in_ready_o is high, or an end-of-line word (kind = 1).
// Output channel (out_valid_o/out_ready_i/out_data_o) gives word and operator
// tokens as start and raw length, then an end marker or an error word per line.
// Each input word yields zero, one or two result words; last_result marks
// the final one of an input word.
// The lexer logic works on the input register and writes its results into
// the result queue, whose head drives the output port.
// Throughput: one input word per cycle while each gives at most one result
// and out_ready_i stays high; a word giving two results is drained one word
// at a time through the one-word output port from the two-entry result queue.
// Reset clears the scan mode to whitespace and both positions to zero.
// When the receiver stalls, the queue fills and in_ready_o drops once the
// held input word no longer fits; no word is lost or repeated.
module shell_command_lexer #(
  parameter int unsigned POS_BITS = scl_pkg::PosBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  scl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output scl_pkg::out_item_t out_data_o
);
  import scl_pkg::*;

  in_item_t            in_q;
  logic                in_vld_q;
  scan_mode_e          mode_q;
  scan_mode_e          mode_d;
  logic [POS_BITS-1:0] pos_q;
  logic [POS_BITS-1:0] pos_d;
  logic [POS_BITS-1:0] start_q;
  logic [POS_BITS-1:0] start_d;
  out_item_t           res0;
  out_item_t           res1;
  logic [1:0]          res_num;
  logic [1:0]          free;
  logic [1:0]          res_cnt;
  logic                fire;
  logic                pop;

  scl_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .mode_q_i (mode_q),
    .pos_q_i  (pos_q),
    .start_q_i(start_q),
    .item_i   (in_q),
    .mode_d_o (mode_d),
    .pos_d_o  (pos_d),
    .start_d_o(start_d),
    .res0_o   (res0),
    .res1_o   (res1),
    .num_o    (res_num)
  );

  assign pop        = out_valid_o && out_ready_i;
  assign fire       = in_vld_q && (res_num <= free);
  assign in_ready_o = !in_vld_q || fire;

  scl_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_num_i(fire ? res_num : 2'd0),
    .push0_i   (res0),
    .push1_i   (res1),
    .pop_i     (pop),
    .free_o    (free),
    .count_o   (res_cnt),
    .valid_o   (out_valid_o),
    .head_o    (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_WS;
      pos_q    <= '0;
      start_q  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt <= 2'd2)
    else $error("result queue overfilled");

  a_eol_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_q.kind == KIND_EOL) |=> (pos_q == '0) && (mode_q == MODE_WS))
    else $error("end of line did not restart the line");

  a_over_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OVER) |-> (pos_q == '1))
    else $error("overflow mode below the position limit");

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_result |-> res_cnt == 2'd2)
    else $error("first of a token pair without its partner");
`endif

endmodule
